// ===== rtl/sqlps_pkg.sv =====
package sqlps_pkg;

  // Byte codes used by the scanners
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Longest command keyword, in characters
  localparam int CMD_CHARS = 8;

  // WHERE window: six bytes, oldest in the low byte
  localparam int WIN_BITS = 48;
  localparam logic [WIN_BITS-1:0] WIN_RESET = {6{CH_SPACE}};
  // "WHERE" as it sits in window bytes 1..5 (W lowest)
  localparam logic [39:0] WHERE_WORD = "EREHW";

  typedef enum logic [3:0] {
    QS_NORMAL, QS_SLASH, QS_DASH, QS_SQ, QS_SQ_ESC, QS_SQ_QUOTE,
    QS_DQ, QS_DQ_ESC, QS_DQ_QUOTE, QS_BLOCK, QS_BLOCK_STAR, QS_LINE
  } qs_mode_t;

  typedef enum logic [2:0] {
    SM_PLAIN, SM_SLASH, SM_DASH, SM_BLOCK, SM_BLOCK_STAR, SM_LINE
  } sm_mode_t;

  typedef enum logic [1:0] {
    KP_BEFORE, KP_IN, KP_DONE
  } kp_phase_t;

  typedef enum logic [3:0] {
    CMD_UNKNOWN, CMD_SELECT, CMD_INSERT, CMD_UPDATE, CMD_DELETE, CMD_DROP,
    CMD_TRUNCATE, CMD_ALTER, CMD_CREATE, CMD_CALL, CMD_PREPARE, CMD_EXECUTE
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK, ST_EMPTY, ST_MULTI, ST_EMPTY_STRIPPED
  } status_t;

  // Quote scanner step result
  typedef struct packed {
    qs_mode_t mode;
    logic     semi;
  } scan_t;

  // Stripper step for plain text: optional emitted byte and next mode
  typedef struct packed {
    logic       en;
    logic [7:0] data;
    sm_mode_t   mode;
  } strip_op_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_sep(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_NL);
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "0" && c <= "9") || (c == "_");
  endfunction

  function automatic logic [7:0] to_up(input logic [7:0] c);
    return (c >= "a" && c <= "z") ? (c - 8'd32) : c;
  endfunction

  // Keyword text, first character in the low byte
  function automatic logic [CMD_CHARS*8-1:0] cmd_name(input cmd_t k);
    logic [CMD_CHARS*8-1:0] r;
    r = '0;
    unique case (k)
      CMD_SELECT:   r = 64'("TCELES");
      CMD_INSERT:   r = 64'("TRESNI");
      CMD_UPDATE:   r = 64'("ETADPU");
      CMD_DELETE:   r = 64'("ETELED");
      CMD_DROP:     r = 64'("PORD");
      CMD_TRUNCATE: r = 64'("ETACNURT");
      CMD_ALTER:    r = 64'("RETLA");
      CMD_CREATE:   r = 64'("ETAERC");
      CMD_CALL:     r = 64'("LLAC");
      CMD_PREPARE:  r = 64'("ERAPERP");
      CMD_EXECUTE:  r = 64'("ETUCEXE");
      default:      r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] cmd_len(input cmd_t k);
    logic [3:0] r;
    r = 4'd0;
    unique case (k)
      CMD_DROP, CMD_CALL:                 r = 4'd4;
      CMD_ALTER:                          r = 4'd5;
      CMD_PREPARE, CMD_EXECUTE:           r = 4'd7;
      CMD_TRUNCATE:                       r = 4'd8;
      CMD_SELECT, CMD_INSERT, CMD_UPDATE,
      CMD_DELETE, CMD_CREATE:             r = 4'd6;
      default:                            r = 4'd0;
    endcase
    return r;
  endfunction

  function automatic scan_t scan_normal(input logic [7:0] c);
    scan_t r;
    r.mode = QS_NORMAL;
    r.semi = 1'b0;
    priority if (c == CH_SQ)    r.mode = QS_SQ;
    else if (c == CH_DQ)        r.mode = QS_DQ;
    else if (c == CH_SLASH)     r.mode = QS_SLASH;
    else if (c == CH_DASH)      r.mode = QS_DASH;
    else if (c == CH_HASH)      r.mode = QS_LINE;
    else if (c == CH_SEMI)      r.semi = 1'b1;
    else                        r.mode = QS_NORMAL;
    return r;
  endfunction

  // One byte through the quote/comment scanner
  function automatic scan_t scan_step(input qs_mode_t m, input logic [7:0] c);
    scan_t r;
    r.mode = m;
    r.semi = 1'b0;
    unique case (m)
      QS_SLASH:      if (c == CH_STAR) r.mode = QS_BLOCK; else r = scan_normal(c);
      QS_DASH:       if (c == CH_DASH) r.mode = QS_LINE; else r = scan_normal(c);
      QS_SQ: begin
        if (c == CH_BSL) r.mode = QS_SQ_ESC;
        else if (c == CH_SQ) r.mode = QS_SQ_QUOTE;
      end
      QS_SQ_ESC:     r.mode = QS_SQ;
      QS_SQ_QUOTE:   if (c == CH_SQ) r.mode = QS_SQ; else r = scan_normal(c);
      QS_DQ: begin
        if (c == CH_BSL) r.mode = QS_DQ_ESC;
        else if (c == CH_DQ) r.mode = QS_DQ_QUOTE;
      end
      QS_DQ_ESC:     r.mode = QS_DQ;
      QS_DQ_QUOTE:   if (c == CH_DQ) r.mode = QS_DQ; else r = scan_normal(c);
      QS_BLOCK:      if (c == CH_STAR) r.mode = QS_BLOCK_STAR;
      QS_BLOCK_STAR: begin
        if (c == CH_SLASH) r.mode = QS_NORMAL;
        else if (c != CH_STAR) r.mode = QS_BLOCK;
      end
      QS_LINE:       if (c == CH_NL) r.mode = QS_NORMAL;
      default:       r = scan_normal(c);
    endcase
    return r;
  endfunction

  // Stripper on a plain-text byte; slash and dash as final byte stay text
  function automatic strip_op_t strip_plain(input logic [7:0] c, input logic last);
    strip_op_t r;
    r.en   = 1'b0;
    r.data = c;
    r.mode = SM_PLAIN;
    priority if (c == CH_SLASH) begin
      if (last) r.en = 1'b1; else r.mode = SM_SLASH;
    end else if (c == CH_DASH) begin
      if (last) r.en = 1'b1; else r.mode = SM_DASH;
    end else if (c == CH_HASH) begin
      r.mode = SM_LINE;
    end else begin
      r.en = 1'b1;
    end
    return r;
  endfunction

endpackage

// ===== rtl/sql_statement_prescreen.sv =====
// SQL statement prescreen: one statement streamed in, one byte per beat.
// Throughput: one byte per cycle; tready drops only while both result stages are
// full. Each byte updates all three trackers (up to two stripped bytes) as it is accepted.
// The result of a statement is registered into the output stage when its last beat is
// accepted, or into the skid stage while the output stage is held, and moves up once taken.
// Reset (rst, synchronous, active high) idles every tracker and empties both result stages.
module sql_statement_prescreen #(
  parameter int KEYWORD_CHARS = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] byte_req
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [3:0] command, [5:4] status, [6] where flag
);
  import sqlps_pkg::*;

  localparam int CW      = $clog2(KEYWORD_CHARS + 1);
  localparam int KW_BITS = KEYWORD_CHARS * 8;
  localparam logic [CW-1:0] KW_MAX = CW'(KEYWORD_CHARS);

  // Stripped-text tracker state: first-token matcher and WHERE detector
  typedef struct packed {
    kp_phase_t           phase;
    logic                bad;
    logic                run_active;
    logic                run_vf;
    logic                run_sep;
    logic [CW-1:0]       count;
    logic [KW_BITS-1:0]  chars;
    logic                nonspace;
    logic [WIN_BITS-1:0] window;
    logic                found;
  } feed_t;

  localparam feed_t FEED_RESET = '{
    phase: KP_BEFORE, bad: 1'b0, run_active: 1'b0, run_vf: 1'b0, run_sep: 1'b0,
    count: '0, chars: '0, nonspace: 1'b0, window: WIN_RESET, found: 1'b0
  };

  function automatic logic where_end(input logic [WIN_BITS-1:0] w);
    return !is_word(w[7:0]) && (w[47:8] == WHERE_WORD);
  endfunction

  // One stripped byte through the token matcher and WHERE window
  function automatic feed_t feed(input feed_t s, input logic [7:0] raw);
    feed_t      n;
    logic [7:0] c;
    logic       ws;
    logic       add;
    n   = s;
    c   = to_up(raw);
    ws  = is_ws(c);
    add = 1'b0;
    if (!ws) n.nonspace = 1'b1;

    unique case (s.phase)
      KP_BEFORE: begin
        if (!ws) begin
          n.phase = KP_IN;
          add     = 1'b1;
        end
      end
      KP_IN: begin
        if (ws) begin
          n.run_active = 1'b1;
          if (is_sep(c)) n.run_sep = 1'b1;
          else if (!s.run_sep) n.run_vf = 1'b1;
        end else if (s.run_active) begin
          if (s.run_vf) n.bad = 1'b1;
          n.run_active = 1'b0;
          n.run_vf     = 1'b0;
          n.run_sep    = 1'b0;
          if (s.run_sep) n.phase = KP_DONE;
          else add = 1'b1;
        end else begin
          add = 1'b1;
        end
      end
      default: ;
    endcase

    // Append to the token buffer, or flag it too long
    if (add) begin
      if (s.count < KW_MAX) begin
        for (int i = 0; i < KEYWORD_CHARS; i++) begin
          if (s.count == CW'(i)) n.chars[i*8 +: 8] = c;
        end
        n.count = CW'(s.count + 1'b1);
      end else begin
        n.bad = 1'b1;
      end
    end

    if (where_end(s.window) && !is_word(c)) n.found = 1'b1;
    n.window = {c, s.window[WIN_BITS-1:8]};
    return n;
  endfunction

  // Tracker registers
  qs_mode_t qs_mode, qs_mode_next;
  logic     semi_seen, semi_seen_next;
  sm_mode_t sm_mode, sm_mode_next;
  logic     raw_nonspace, raw_nonspace_next;
  feed_t    fs, fs_next;

  // Result stages
  logic       out_valid, skid_valid;
  logic [6:0] out_data, skid_data;

  logic       s_fire, m_fire;
  logic [7:0] c_in;
  logic       last_in;
  scan_t      scan;
  logic       f1_en, f2_en;
  logic [7:0] f1_byte, f2_byte;
  strip_op_t  pop;
  feed_t      fs1, fs2;
  cmd_t       cmd_res;
  status_t    st_res;
  logic       where_res;
  logic [6:0] res;

  assign s_fire  = s_axis_tvalid && s_axis_tready;
  assign m_fire  = m_axis_tvalid && m_axis_tready;
  assign c_in    = s_axis_tdata;
  assign last_in = s_axis_tlast;

  // Quote scanner and raw non-space flag
  always_comb begin
    scan              = scan_step(qs_mode, c_in);
    qs_mode_next      = scan.mode;
    semi_seen_next    = semi_seen | scan.semi;
    raw_nonspace_next = raw_nonspace | !is_ws(c_in);
  end

  // Comment stripper: up to two bytes emitted per input byte
  always_comb begin
    pop          = strip_plain(c_in, last_in);
    f1_en        = 1'b0;
    f1_byte      = CH_SPACE;
    f2_en        = 1'b0;
    f2_byte      = c_in;
    sm_mode_next = sm_mode;
    unique case (sm_mode)
      SM_SLASH: begin
        if (c_in == CH_STAR) begin
          if (last_in) begin
            f1_en        = 1'b1;
            sm_mode_next = SM_PLAIN;
          end else begin
            sm_mode_next = SM_BLOCK;
          end
        end else begin
          f1_en        = 1'b1;
          f1_byte      = CH_SLASH;
          f2_en        = pop.en;
          sm_mode_next = pop.mode;
        end
      end
      SM_DASH: begin
        if (c_in == CH_DASH) begin
          sm_mode_next = SM_LINE;
        end else begin
          f1_en        = 1'b1;
          f1_byte      = CH_DASH;
          f2_en        = pop.en;
          sm_mode_next = pop.mode;
        end
      end
      SM_BLOCK, SM_BLOCK_STAR: begin
        if (sm_mode == SM_BLOCK_STAR && c_in == CH_SLASH) begin
          f1_en        = 1'b1;
          sm_mode_next = SM_PLAIN;
        end else if (last_in) begin
          // unterminated comment: one space, then the byte as text
          f1_en        = 1'b1;
          f2_en        = pop.en;
          sm_mode_next = pop.mode;
        end else begin
          sm_mode_next = (c_in == CH_STAR) ? SM_BLOCK_STAR : SM_BLOCK;
        end
      end
      SM_LINE: begin
        if (c_in == CH_NL) begin
          f2_en        = 1'b1;
          sm_mode_next = SM_PLAIN;
        end
      end
      default: begin
        f2_en        = pop.en;
        sm_mode_next = pop.mode;
      end
    endcase
  end

  // Two chained passes through the stripped-text tracker
  always_comb begin
    fs1     = f1_en ? feed(fs, f1_byte) : fs;
    fs2     = f2_en ? feed(fs1, f2_byte) : fs1;
    fs_next = fs2;
  end

  // Classification on the final byte
  always_comb begin
    cmd_res   = CMD_UNKNOWN;
    where_res = 1'b0;
    priority if (!raw_nonspace_next) begin
      st_res = ST_EMPTY;
    end else if (semi_seen_next) begin
      st_res = ST_MULTI;
    end else if (!fs2.nonspace) begin
      st_res = ST_EMPTY_STRIPPED;
    end else begin
      st_res    = ST_OK;
      where_res = fs2.found || where_end(fs2.window);
      if (!fs2.bad && fs2.phase != KP_BEFORE) begin
        for (int k = int'(CMD_EXECUTE); k >= int'(CMD_SELECT); k--) begin
          if (32'(fs2.count) == 32'(cmd_len(cmd_t'(k))) &&
              (fs2.chars[CMD_CHARS*8-1:0] &
               ((64'h1 << (8 * cmd_len(cmd_t'(k)))) - 64'h1)) == cmd_name(cmd_t'(k)))
            cmd_res = cmd_t'(k);
        end
      end
    end
    res = {where_res, st_res, cmd_res};
  end

  // Tracker state: back to idle after each statement
  always_ff @(posedge clk) begin
    if (rst) begin
      qs_mode      <= QS_NORMAL;
      semi_seen    <= 1'b0;
      sm_mode      <= SM_PLAIN;
      raw_nonspace <= 1'b0;
      fs           <= FEED_RESET;
    end else if (s_fire) begin
      if (last_in) begin
        qs_mode      <= QS_NORMAL;
        semi_seen    <= 1'b0;
        sm_mode      <= SM_PLAIN;
        raw_nonspace <= 1'b0;
        fs           <= FEED_RESET;
      end else begin
        qs_mode      <= qs_mode_next;
        semi_seen    <= semi_seen_next;
        sm_mode      <= sm_mode_next;
        raw_nonspace <= raw_nonspace_next;
        fs           <= fs_next;
      end
    end
  end

  // Output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (m_fire) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= s_fire && last_in;
        end
      end else if (!out_valid) begin
        out_valid <= s_fire && last_in;
      end else if (s_fire && last_in) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (m_fire && skid_valid) begin
      out_data <= skid_data;
    end else if ((m_fire || !out_valid) && s_fire && last_in) begin
      out_data <= res;
    end
    if (out_valid && !m_fire && s_fire && last_in) begin
      skid_data <= res;
    end
  end

  assign s_axis_tready = !skid_valid;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_data};

  // Checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage holds a result while the output stage is empty");

  a_result_follows_last: assert property (@(posedge clk) disable iff (rst)
    (s_fire && s_axis_tlast) |=> m_axis_tvalid)
    else $error("no result after the last beat of a statement");

  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    (s_fire && s_axis_tlast) |=>
      (qs_mode == QS_NORMAL && sm_mode == SM_PLAIN && fs.phase == KP_BEFORE &&
       !semi_seen && !raw_nonspace))
    else $error("trackers not back to idle after a statement");

  a_error_clears_fields: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[5:4] != ST_OK) |->
      (m_axis_tdata[3:0] == CMD_UNKNOWN && !m_axis_tdata[6]))
    else $error("command or where flag set on an error status");

endmodule

// ===== test/tb_sql_statement_prescreen.sv =====
`timescale 1ns / 1ps

module tb_sql_statement_prescreen;
  import sqlps_pkg::*;

  localparam int KW_MAX     = CMD_CHARS;
  localparam int RAND_BYTES = 700;
  localparam int IDLE_LIMIT = 2000;

  logic       clk = 1'b0;
  logic       rst;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;
  logic       s_axis_tlast;
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;

  // One classification as the block reports it
  typedef struct {
    cmd_t    cmd;
    status_t status;
    logic    where_flag;
  } verdict_t;

  // Predicts the verdict of each statement and checks the result beats
  class prescreen_board;
    verdict_t  pending[$];
    int        errors;
    int        n_bytes, n_stmts, n_ok, n_empty, n_multi, n_bare, n_where;
    bit [15:0] cmd_seen;

    // quote/comment scanner
    qs_mode_t   qmode;
    logic       semi;
    // comment stripper
    sm_mode_t   smode;
    logic       raw_ns, strip_ns;
    // first-token matcher
    logic [7:0] kw_buf[KW_MAX];
    int         kw_len;
    kp_phase_t  kphase;
    logic       kw_bad;
    logic       run_act, run_vf, run_sep;
    // WHERE detector, oldest byte at index 0
    logic [7:0] win[6];
    logic       where_hit;

    function new();
      clear();
    endfunction

    function void clear();
      qmode = QS_NORMAL;
      semi = 1'b0;
      smode = SM_PLAIN;
      raw_ns = 1'b0;
      strip_ns = 1'b0;
      foreach (kw_buf[i]) kw_buf[i] = 8'h00;
      kw_len = 0;
      kphase = KP_BEFORE;
      kw_bad = 1'b0;
      run_act = 1'b0;
      run_vf = 1'b0;
      run_sep = 1'b0;
      foreach (win[i]) win[i] = CH_SPACE;
      where_hit = 1'b0;
    endfunction

    static function string cmd_text(cmd_t k);
      case (k)
        CMD_SELECT:   return "SELECT";
        CMD_INSERT:   return "INSERT";
        CMD_UPDATE:   return "UPDATE";
        CMD_DELETE:   return "DELETE";
        CMD_DROP:     return "DROP";
        CMD_TRUNCATE: return "TRUNCATE";
        CMD_ALTER:    return "ALTER";
        CMD_CREATE:   return "CREATE";
        CMD_CALL:     return "CALL";
        CMD_PREPARE:  return "PREPARE";
        CMD_EXECUTE:  return "EXECUTE";
        default:      return "";
      endcase
    endfunction

    static function logic is_blank(logic [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    // separators that end the first token
    static function logic is_break(logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_NL;
    endfunction

    static function logic is_word_ch(logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "0" && c <= "9") || c == "_";
    endfunction

    function logic where_closes();
      string w = "WHERE";
      if (is_word_ch(win[0])) return 1'b0;
      for (int i = 0; i < 5; i++)
        if (win[i+1] != w[i]) return 1'b0;
      return 1'b1;
    endfunction

    function void kw_push(logic [7:0] c);
      if (kw_len < KW_MAX) begin
        kw_buf[kw_len] = c;
        kw_len++;
      end else begin
        kw_bad = 1'b1;
      end
    endfunction

    // One byte of stripped text into the token matcher and WHERE window
    function void feed_char(logic [7:0] raw);
      logic [7:0] c;
      logic       ws;
      c = (raw >= "a" && raw <= "z") ? (raw & 8'hDF) : raw;
      ws = is_blank(c);
      if (!ws) strip_ns = 1'b1;
      case (kphase)
        KP_BEFORE: begin
          if (!ws) begin
            kphase = KP_IN;
            kw_push(c);
          end
        end
        KP_IN: begin
          if (ws) begin
            run_act = 1'b1;
            if (is_break(c)) run_sep = 1'b1;
            else if (!run_sep) run_vf = 1'b1;
          end else if (run_act) begin
            // VT/FF inside the token spoils it; a real separator ends it
            if (run_vf) kw_bad = 1'b1;
            if (run_sep) kphase = KP_DONE;
            else kw_push(c);
            run_act = 1'b0;
            run_vf = 1'b0;
            run_sep = 1'b0;
          end else begin
            kw_push(c);
          end
        end
        default: ;
      endcase
      if (where_closes() && !is_word_ch(c)) where_hit = 1'b1;
      for (int i = 0; i < 5; i++) win[i] = win[i+1];
      win[5] = c;
    endfunction

    // Stripper on a byte seen as plain text; slash or dash as final byte stay text
    function void strip_text(logic [7:0] c, logic last);
      smode = SM_PLAIN;
      if (c == CH_SLASH) begin
        if (last) feed_char(c);
        else smode = SM_SLASH;
      end else if (c == CH_DASH) begin
        if (last) feed_char(c);
        else smode = SM_DASH;
      end else if (c == CH_HASH) begin
        smode = SM_LINE;
      end else begin
        feed_char(c);
      end
    endfunction

    function void strip(logic [7:0] c, logic last);
      case (smode)
        SM_SLASH: begin
          if (c == CH_STAR) begin
            if (last) begin
              feed_char(CH_SPACE);
              smode = SM_PLAIN;
            end else begin
              smode = SM_BLOCK;
            end
          end else begin
            feed_char(CH_SLASH);
            strip_text(c, last);
          end
        end
        SM_DASH: begin
          if (c == CH_DASH) begin
            smode = SM_LINE;
          end else begin
            feed_char(CH_DASH);
            strip_text(c, last);
          end
        end
        SM_BLOCK, SM_BLOCK_STAR: begin
          if (smode == SM_BLOCK_STAR && c == CH_SLASH) begin
            smode = SM_PLAIN;
            feed_char(CH_SPACE);
          end else if (last) begin
            // unterminated comment: one space, then the byte as text
            feed_char(CH_SPACE);
            strip_text(c, last);
          end else begin
            smode = (c == CH_STAR) ? SM_BLOCK_STAR : SM_BLOCK;
          end
        end
        SM_LINE: begin
          if (c == CH_NL) begin
            smode = SM_PLAIN;
            feed_char(c);
          end
        end
        default: strip_text(c, last);
      endcase
    endfunction

    // Scanner leaving a quote or comment, or in plain text
    function void scan_open(logic [7:0] c);
      qmode = QS_NORMAL;
      if (c == CH_SQ) qmode = QS_SQ;
      else if (c == CH_DQ) qmode = QS_DQ;
      else if (c == CH_SLASH) qmode = QS_SLASH;
      else if (c == CH_DASH) qmode = QS_DASH;
      else if (c == CH_HASH) qmode = QS_LINE;
      else if (c == CH_SEMI) semi = 1'b1;
    endfunction

    function void scan(logic [7:0] c);
      case (qmode)
        QS_SLASH:      if (c == CH_STAR) qmode = QS_BLOCK; else scan_open(c);
        QS_DASH:       if (c == CH_DASH) qmode = QS_LINE; else scan_open(c);
        QS_SQ: begin
          if (c == CH_BSL) qmode = QS_SQ_ESC;
          else if (c == CH_SQ) qmode = QS_SQ_QUOTE;
        end
        QS_SQ_ESC:     qmode = QS_SQ;
        QS_SQ_QUOTE:   if (c == CH_SQ) qmode = QS_SQ; else scan_open(c);
        QS_DQ: begin
          if (c == CH_BSL) qmode = QS_DQ_ESC;
          else if (c == CH_DQ) qmode = QS_DQ_QUOTE;
        end
        QS_DQ_ESC:     qmode = QS_DQ;
        QS_DQ_QUOTE:   if (c == CH_DQ) qmode = QS_DQ; else scan_open(c);
        QS_BLOCK:      if (c == CH_STAR) qmode = QS_BLOCK_STAR;
        QS_BLOCK_STAR: begin
          if (c == CH_SLASH) qmode = QS_NORMAL;
          else if (c != CH_STAR) qmode = QS_BLOCK;
        end
        QS_LINE:       if (c == CH_NL) qmode = QS_NORMAL;
        default:       scan_open(c);
      endcase
    endfunction

    function cmd_t match_token();
      string name;
      logic  same;
      if (kw_bad || kphase == KP_BEFORE) return CMD_UNKNOWN;
      for (int k = CMD_SELECT; k <= CMD_EXECUTE; k++) begin
        name = cmd_text(cmd_t'(k));
        same = (kw_len == name.len());
        for (int i = 0; same && i < kw_len; i++)
          if (kw_buf[i] != name[i]) same = 1'b0;
        if (same) return cmd_t'(k);
      end
      return CMD_UNKNOWN;
    endfunction

    // Accepted input beat; the last byte of a statement queues its verdict
    function void note_beat(logic [7:0] c, logic last);
      verdict_t v;
      n_bytes++;
      scan(c);
      if (!is_blank(c)) raw_ns = 1'b1;
      strip(c, last);
      if (last) begin
        v.cmd = CMD_UNKNOWN;
        v.status = ST_OK;
        v.where_flag = 1'b0;
        if (!raw_ns) v.status = ST_EMPTY;
        else if (semi) v.status = ST_MULTI;
        else if (!strip_ns) v.status = ST_EMPTY_STRIPPED;
        else begin
          v.cmd = match_token();
          v.where_flag = where_hit || where_closes();
        end
        pending = {pending, v};
        n_stmts++;
        case (v.status)
          ST_OK:    n_ok++;
          ST_EMPTY: n_empty++;
          ST_MULTI: n_multi++;
          default:  n_bare++;
        endcase
        if (v.cmd != CMD_UNKNOWN) cmd_seen[v.cmd] = 1'b1;
        if (v.where_flag) n_where++;
        clear();
      end
    endfunction

    function void check_result(logic [7:0] beat);
      verdict_t want;
      if (pending.size() == 0) begin
        $error("result beat %h arrived with no statement pending", beat);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (beat[3:0] !== want.cmd) begin
        $error("command: expected %0d, got %0d", want.cmd, beat[3:0]);
        errors++;
      end
      if (beat[5:4] !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, beat[5:4]);
        errors++;
      end
      if (beat[6] !== want.where_flag) begin
        $error("where_flag: expected %0d, got %0d", want.where_flag, beat[6]);
        errors++;
      end
    endfunction

    function int outstanding();
      return pending.size();
    endfunction
  endclass

  prescreen_board sb;
  logic [7:0]     stmt[$];
  int             beats;
  bit             quiet;
  int             idle_cycles;

  // Short statements hitting every command and each corner of the trackers
  string directed_stmts[] = '{
    " ",
    "\t\n\013\014\015 ",
    "SELECT * FROM t WHERE id=1",
    "insert into t values (1)",
    "Update t set a = 2 where b",
    "delete from t",
    "drop table t",
    "TRUNCATE t",
    "alter table t",
    "create index i",
    "CALL p()",
    "prepare s from 'x'",
    "execute s",
    "select 1; drop t",
    "select ';' from \"a;\"",
    "select 'it''s;' x",
    "select 'a\\';' where",
    "/* only ; */ -- x;",
    "# c ;\nselect/**/x",
    "SELECTX1 WHERE",
    "truncatex t",
    "SELECT\013x",
    "SELECT\014",
    "drop/* open",
    "select a-",
    "select a/",
    "sel/*c*/ect where_x nowhere",
    "x (where)"
  };

  sql_statement_prescreen #(.KEYWORD_CHARS(KW_MAX)) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk = ~clk;

  // Mostly short gaps, a few long ones, none in quiet stretches
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] pick_char(string set);
    return set[$urandom_range(0, set.len() - 1)];
  endfunction

  function automatic string mixcase(string s);
    for (int i = 0; i < s.len(); i++)
      if (s[i] >= "A" && s[i] <= "Z" && $urandom_range(0, 1)) s[i] = s[i] | 8'h20;
    return s;
  endfunction

  function automatic string rand_word();
    string w;
    int    n;
    w = "";
    n = $urandom_range(1, 10);
    repeat (n) w = {w, string'(pick_char("ABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789abcxyz"))};
    return w;
  endfunction

  // Append one byte to the statement under construction
  task automatic put_byte(logic [7:0] b);
    stmt = {stmt, b};
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  task automatic add_blanks();
    int n;
    n = $urandom_range(1, 3);
    repeat (n) put_byte(pick_char("   \t\n\015\013\014"));
  endtask

  // First token: a command keyword, sometimes bent, or a random word
  task automatic add_keyword();
    int    k;
    string w;
    k = $urandom_range(CMD_UNKNOWN, CMD_EXECUTE);
    if (k == CMD_UNKNOWN) begin
      w = rand_word();
    end else begin
      w = prescreen_board::cmd_text(cmd_t'(k));
      case ($urandom_range(0, 19))
        0: w = {w, string'(pick_char("SXE_1"))};
        1: w = {w.substr(0, 1), "\013", w.substr(2, w.len() - 1)};
        2: w = {w.substr(0, 1), "/**/", w.substr(2, w.len() - 1)};
        3: w = w.substr(0, w.len() - 2);
        default: ;
      endcase
    end
    add_text(mixcase(w));
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: put_byte(CH_SPACE);
      6: put_byte(pick_char("\t\n\015"));
      7: put_byte(pick_char("\013\014"));
      8: ;
      default: add_text("/*x*/");
    endcase
  endtask

  task automatic add_fragment(int kind);
    logic [7:0] qc;
    int         n;
    n = $urandom_range(0, 5);
    case (kind)
      0: add_text(rand_word());
      1: begin
        put_byte(pick_char(" (_x\n\t\013"));
        add_text(mixcase("WHERE"));
        if ($urandom_range(0, 3) != 0) put_byte(pick_char(" )_1=\n*"));
      end
      2: begin
        // quoted string with escapes, doubled quotes and semicolons
        qc = $urandom_range(0, 1) ? CH_SQ : CH_DQ;
        put_byte(qc);
        repeat (n) begin
          case ($urandom_range(0, 5))
            0: begin
              put_byte(CH_BSL);
              put_byte(pick_char("'\";\\a"));
            end
            1: begin
              put_byte(qc);
              put_byte(qc);
            end
            2: put_byte(CH_SEMI);
            default: put_byte(pick_char("abc XYZ-/*#'\""));
          endcase
        end
        if ($urandom_range(0, 6) != 0) put_byte(qc);
      end
      3: begin
        add_text("/*");
        repeat (n) put_byte(pick_char("ab*;/'-\n "));
        if ($urandom_range(0, 6) != 0) add_text("*/");
      end
      4: begin
        add_text($urandom_range(0, 1) ? "--" : "#");
        repeat (n) put_byte(pick_char("ab;'\"*/ "));
        if ($urandom_range(0, 4) != 0) put_byte(CH_NL);
      end
      5: put_byte(CH_SEMI);
      6: add_blanks();
      7: repeat (n % 3 + 1) put_byte(8'($urandom_range(0, 255)));
      8: put_byte(pick_char("/-*\\"));
      default: add_text({" ", rand_word(), " "});
    endcase
  endtask

  // Mostly statement-shaped text; some blank-only and raw noise
  task automatic build_stmt();
    int r, n;
    stmt.delete();
    r = $urandom_range(0, 99);
    n = $urandom_range(0, 5);
    if (r < 5) begin
      add_blanks();
    end else if (r < 12) begin
      repeat (n * 2 + 1) put_byte(8'($urandom_range(0, 255)));
    end else begin
      if ($urandom_range(0, 3) == 0) add_blanks();
      if ($urandom_range(0, 5) == 0) add_fragment($urandom_range(3, 4));
      add_keyword();
      repeat (n) add_fragment($urandom_range(0, 9));
    end
  endtask

  // Drive one byte; returns at the edge that accepts it
  task automatic send_beat(logic [7:0] b, logic is_last);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = b;
    s_axis_tlast = is_last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_beat(b, is_last);
    beats++;
  endtask

  task automatic send_stmt();
    for (int i = 0; i < stmt.size(); i++) send_beat(stmt[i], i == stmt.size() - 1);
  endtask

  // Result side: random stalls on tready
  initial begin
    int hold;
    m_axis_tready = 1'b0;
    hold = 0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
      end else if (m_axis_tready) begin
        hold = pick_gap();
        if (hold > 0) begin
          m_axis_tready = 1'b0;
          hold--;
        end
      end else begin
        m_axis_tready = 1'b1;
        hold = $urandom_range(0, 6);
      end
    end
  end

  // Check every accepted result beat
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // Watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d results outstanding",
               idle_cycles, sb.outstanding());
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int start;
    sb = new();
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = 8'h00;
    s_axis_tlast = 1'b0;
    quiet = 1'b0;
    beats = 0;
    idle_cycles = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed statements
    foreach (directed_stmts[i]) begin
      stmt.delete();
      add_text(directed_stmts[i]);
      send_stmt();
    end

    // random statements, now and then a stretch with no gaps
    start = beats;
    while (beats - start < RAND_BYTES) begin
      quiet = ($urandom_range(0, 7) == 0);
      build_stmt();
      send_stmt();
    end
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    s_axis_tlast = 1'b0;
    quiet = 1'b0;

    // drain, then wait for anything stray
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("summary: %0d statements in %0d bytes; ok %0d, empty %0d, multi %0d, bare %0d",
             sb.n_stmts, sb.n_bytes, sb.n_ok, sb.n_empty, sb.n_multi, sb.n_bare);
    $display("summary: %0d of 11 commands recognized, WHERE flagged in %0d statements",
             $countones(sb.cmd_seen), sb.n_where);
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
